/* design/spk_pkg.sv */
// ----------------------------------------------------------------------------
// spk_pkg: shared types, constants and helpers for the Speck48/96 core
// Word width, round counts, mode codes, request/response payloads and the
// pipeline stage payload carried between schedule and round stages.
// ----------------------------------------------------------------------------
package spk_pkg;

   localparam int WORD_W      = 24;
   localparam int SCHED_STEPS = 22;
   localparam int ROUNDS      = 23;
   localparam int IDX_W       = $clog2(ROUNDS);

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [IDX_W-1:0]  idx_type;

   typedef struct packed {
      logic     req_type;
      word_type key_word_0;
      word_type key_word_1;
      word_type key_word_2;
      word_type key_word_3;
      word_type block_low;
      word_type block_high;
   } spk_req_type;

   typedef struct packed {
      word_type out_low;
      word_type out_high;
   } spk_rsp_type;

   // Payload of one pipeline stage. keys holds the schedule as it fills in.
   typedef struct packed {
      logic                  mode;
      word_type              x;
      word_type              y;
      word_type              ell0;
      word_type              ell1;
      word_type              ell2;
      word_type              rk_cur;
      word_type [ROUNDS-1:0] keys;
   } spk_stage_type;

   function automatic word_type rotl(input word_type v, input int unsigned r);
      rotl = (v << r) | (v >> (WORD_W - r));
   endfunction

endpackage

/* design/speck48_96_block_cipher_core.sv */
// ----------------------------------------------------------------------------
// speck48_96_block_cipher_core: fully pipelined Speck48/96 encrypt/decrypt
// Takes one request per cycle and returns the results in request order.
// ----------------------------------------------------------------------------
// Users: busy is always low, so a request is taken at every clock edge with
// start high, one per cycle, each carrying its own key and mode. The result
// is strobed with rsp_valid high for exactly one cycle once it has passed
// every stage, in request order. Capture it then, since there is no way to
// hold it off.
// The chain is one capture register, 22 key schedule stages (one
// schedule step each, a 24-bit add per stage), then 23 round stages (one
// add-rotate-xor round, or its inverse, each). The full schedule is built
// before any round runs so decryption can take the keys from last to first.
// Reset clears only the valid bits.
module speck48_96_block_cipher_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  spk_pkg::spk_req_type req_data,
   output logic                 rsp_valid,
   output spk_pkg::spk_rsp_type rsp_data
);

   localparam int STAGES = 1 + spk_pkg::SCHED_STEPS + spk_pkg::ROUNDS;

   logic                   valid_q [STAGES];
   spk_pkg::spk_stage_type data_q  [STAGES];

   logic                   entry_valid_ff;
   spk_pkg::spk_stage_type entry_data_ff;
   spk_pkg::spk_stage_type entry_data_in;

   // The pipeline never stalls.
   assign busy = 1'b0;

   // Load ell and the first round key; later key slots fill in downstream.
   always_comb begin
      entry_data_in         = '0;
      entry_data_in.mode    = req_data.req_type;
      entry_data_in.x       = req_data.block_low;
      entry_data_in.y       = req_data.block_high;
      entry_data_in.ell0    = req_data.key_word_2;
      entry_data_in.ell1    = req_data.key_word_1;
      entry_data_in.ell2    = req_data.key_word_0;
      entry_data_in.rk_cur  = req_data.key_word_3;
      entry_data_in.keys[0] = req_data.key_word_3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= start & ~busy;
      end
      entry_data_ff <= entry_data_in;
   end

   assign valid_q[0] = entry_valid_ff;
   assign data_q[0]  = entry_data_ff;

   // Key schedule: stage k produces round key k+1.
   for (genvar k = 0; k < spk_pkg::SCHED_STEPS; k++) begin : g_key
      spk_key_stage u_key (
         .clock    (clock),
         .reset    (reset),
         .step_idx (spk_pkg::idx_type'(k)),
         .in_valid (valid_q[k]),
         .in_data  (data_q[k]),
         .out_valid(valid_q[k+1]),
         .out_data (data_q[k+1])
      );
   end

   // Cipher rounds: stage r applies round r (or its inverse).
   for (genvar r = 0; r < spk_pkg::ROUNDS; r++) begin : g_round
      spk_round_stage u_round (
         .clock    (clock),
         .reset    (reset),
         .step_idx (spk_pkg::idx_type'(r)),
         .in_valid (valid_q[spk_pkg::SCHED_STEPS + r]),
         .in_data  (data_q[spk_pkg::SCHED_STEPS + r]),
         .out_valid(valid_q[spk_pkg::SCHED_STEPS + r + 1]),
         .out_data (data_q[spk_pkg::SCHED_STEPS + r + 1])
      );
   end

   assign rsp_valid         = valid_q[STAGES-1];
   assign rsp_data.out_low  = data_q[STAGES-1].x;
   assign rsp_data.out_high = data_q[STAGES-1].y;

endmodule

/* design/spk_key_stage.sv */
// ----------------------------------------------------------------------------
// spk_key_stage: one registered step of the key schedule
// Derives the next round key and ell word and stores the key in the table.
// ----------------------------------------------------------------------------
module spk_key_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  spk_pkg::idx_type       step_idx,
   input  logic                   in_valid,
   input  spk_pkg::spk_stage_type in_data,
   output logic                   out_valid,
   output spk_pkg::spk_stage_type out_data
);

   logic                   valid_ff;
   spk_pkg::spk_stage_type data_ff;
   spk_pkg::spk_stage_type data_in;
   spk_pkg::word_type      fresh;
   spk_pkg::word_type      rk_next;

   always_comb begin
      fresh   = (spk_pkg::rotl(in_data.ell0, 16) + in_data.rk_cur)
                ^ spk_pkg::word_type'(step_idx);
      rk_next = spk_pkg::rotl(in_data.rk_cur, 3) ^ fresh;
      data_in        = in_data;
      data_in.ell0   = in_data.ell1;
      data_in.ell1   = in_data.ell2;
      data_in.ell2   = fresh;
      data_in.rk_cur = rk_next;
      data_in.keys[spk_pkg::idx_type'(step_idx + 1'b1)] = rk_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* design/spk_round_stage.sv */
// ----------------------------------------------------------------------------
// spk_round_stage: one registered cipher round, forward or inverse
// Encrypt uses round key step_idx; decrypt uses the mirrored key.
// ----------------------------------------------------------------------------
module spk_round_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  spk_pkg::idx_type       step_idx,
   input  logic                   in_valid,
   input  spk_pkg::spk_stage_type in_data,
   output logic                   out_valid,
   output spk_pkg::spk_stage_type out_data
);

   logic                   valid_ff;
   spk_pkg::spk_stage_type data_ff;
   spk_pkg::spk_stage_type data_in;
   spk_pkg::word_type      rkey;
   spk_pkg::word_type      enc_x;
   spk_pkg::word_type      dec_y;
   spk_pkg::idx_type       rev_idx;

   always_comb begin
      rev_idx = spk_pkg::idx_type'(spk_pkg::ROUNDS - 1) - step_idx;
      rkey    = (in_data.mode == spk_pkg::MODE_DECRYPT) ? in_data.keys[rev_idx]
                                                        : in_data.keys[step_idx];
      enc_x   = (spk_pkg::rotl(in_data.x, 16) + in_data.y) ^ rkey;
      dec_y   = spk_pkg::rotl(in_data.x ^ in_data.y, 21);
      data_in = in_data;
      if (in_data.mode == spk_pkg::MODE_DECRYPT) begin
         data_in.y = dec_y;
         data_in.x = spk_pkg::rotl((in_data.x ^ rkey) - dec_y, 8);
      end else begin
         data_in.x = enc_x;
         data_in.y = spk_pkg::rotl(in_data.y, 3) ^ enc_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* verif/speck48_96_block_cipher_core_tb.sv */
// ----------------------------------------------------------------------------
// speck48_96_block_cipher_core_tb: self-checking bench for the Speck48/96 core
// Drives directed and random-burst encrypt/decrypt requests and computes every
// expected result with a local cipher model. A scoreboard compares each
// strobed result word by word, in request order, with the oldest prediction.
// ----------------------------------------------------------------------------
module speck48_96_block_cipher_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 400;
   localparam int TAIL_CYCLES     = 60;    // pipeline is 46 deep; leave margin
   localparam int IDLE_LIMIT      = 2000;  // cycles with no request and no result

   // -------------------------------------------------------------------------
   // Scoreboard: predicts each request's result and checks strobed results
   // -------------------------------------------------------------------------
   class cipher_scoreboard;
      spk_pkg::spk_rsp_type expected_q[$];
      int                   mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Rotate a 24-bit word left by n (n < 24) through a doubled copy.
      static function spk_pkg::word_type rol24(spk_pkg::word_type v, int unsigned n);
         logic [2*spk_pkg::WORD_W-1:0] dbl;
         dbl = {v, v} << n;
         return dbl[2*spk_pkg::WORD_W-1 -: spk_pkg::WORD_W];
      endfunction

      function spk_pkg::spk_rsp_type cipher_result(spk_pkg::spk_req_type r);
         spk_pkg::word_type    rk [spk_pkg::ROUNDS];
         spk_pkg::word_type    l0, l1, l2, sum, fresh, x, y;
         spk_pkg::spk_rsp_type res;
         l0    = r.key_word_2;
         l1    = r.key_word_1;
         l2    = r.key_word_0;
         rk[0] = r.key_word_3;
         for (int i = 0; i < spk_pkg::SCHED_STEPS; i++) begin
            sum       = rol24(l0, 16) + rk[i];
            fresh     = sum ^ spk_pkg::word_type'(i);
            rk[i + 1] = rol24(rk[i], 3) ^ fresh;
            l0        = l1;
            l1        = l2;
            l2        = fresh;
         end
         x = r.block_low;
         y = r.block_high;
         if (r.req_type == spk_pkg::MODE_DECRYPT) begin
            for (int i = spk_pkg::ROUNDS - 1; i >= 0; i--) begin
               y   = rol24(x ^ y, 21);
               sum = (x ^ rk[i]) - y;
               x   = rol24(sum, 8);
            end
         end else begin
            for (int i = 0; i < spk_pkg::ROUNDS; i++) begin
               sum = rol24(x, 16) + y;
               x   = sum ^ rk[i];
               y   = rol24(y, 3) ^ x;
            end
         end
         res.out_low  = x;
         res.out_high = y;
         return res;
      endfunction

      function void note_request(spk_pkg::spk_req_type r);
         expected_q.push_back(cipher_result(r));
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      task report(string what);
         $display("[%0t] MISMATCH: %s", $realtime, what);
         mismatches++;
      endtask

      task check_result(spk_pkg::spk_rsp_type got);
         spk_pkg::spk_rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result %h/%h with no request outstanding",
                             got.out_low, got.out_high));
            return;
         end
         want = expected_q.pop_front();
         if (got.out_low !== want.out_low)
            report($sformatf("out_low %h, expected %h", got.out_low, want.out_low));
         if (got.out_high !== want.out_high)
            report($sformatf("out_high %h, expected %h", got.out_high, want.out_high));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // -------------------------------------------------------------------------
   logic                 clock    = 1'b0;
   logic                 reset    = 1'b1;
   logic                 start    = 1'b0;
   spk_pkg::spk_req_type req_data = '0;
   logic                 busy;
   logic                 rsp_valid;
   spk_pkg::spk_rsp_type rsp_data;

   cipher_scoreboard board = new();
   int               idle_cycles = 0;

   always #2 clock = ~clock;

   speck48_96_block_cipher_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge and run the watchdog
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         // Note a request before checking: a result can never belong to a
         // request taken at the same edge, so order here is harmless.
         if (start && !busy) board.note_request(req_data);
         if (rsp_valid) board.check_result(rsp_data);
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request helpers
   // -------------------------------------------------------------------------
   function automatic spk_pkg::spk_req_type make_req(logic mode,
                                                     spk_pkg::word_type k0,
                                                     spk_pkg::word_type k1,
                                                     spk_pkg::word_type k2,
                                                     spk_pkg::word_type k3,
                                                     spk_pkg::word_type lo,
                                                     spk_pkg::word_type hi);
      spk_pkg::spk_req_type r;
      r.req_type   = mode;
      r.key_word_0 = k0;
      r.key_word_1 = k1;
      r.key_word_2 = k2;
      r.key_word_3 = k3;
      r.block_low  = lo;
      r.block_high = hi;
      return r;
   endfunction

   // Mix in extremes and single-bit patterns so carries and rotations get
   // exercised at the word edges, not just on uniform noise.
   function automatic spk_pkg::word_type pick_word();
      spk_pkg::word_type one_hot;
      one_hot = spk_pkg::word_type'(1) << $urandom_range(0, spk_pkg::WORD_W - 1);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return one_hot;
         3:       return ~one_hot;
         default: return spk_pkg::word_type'($urandom);
      endcase
   endfunction

   function automatic spk_pkg::spk_req_type random_req(logic mode);
      return make_req(mode, pick_word(), pick_word(), pick_word(), pick_word(),
                      pick_word(), pick_word());
   endfunction

   // Present one request from a falling edge and hold it until taken.
   task automatic send_request(spk_pkg::spk_req_type r);
      logic was_busy;
      start    <= 1'b1;
      req_data <= r;
      do begin
         was_busy = busy;
         @(negedge clock);
      end while (was_busy);
   endtask

   // Drop start and hold off until every outstanding result has come back.
   task automatic hold_until_drained();
      start <= 1'b0;
      @(negedge clock);
      while (board.outstanding() != 0) @(negedge clock);
   endtask

   // Encrypt, then decrypt the predicted ciphertext under the same key.
   task automatic send_round_trip(spk_pkg::spk_req_type r);
      spk_pkg::spk_req_type back;
      spk_pkg::spk_rsp_type ct;
      ct              = board.cipher_result(r);
      back            = r;
      back.req_type   = spk_pkg::MODE_DECRYPT;
      back.block_low  = ct.out_low;
      back.block_high = ct.out_high;
      send_request(r);
      send_request(back);
   endtask

   // -------------------------------------------------------------------------
   // Directed requests: extremes, both modes, the published test vector
   // -------------------------------------------------------------------------
   task automatic run_directed();
      spk_pkg::word_type ones, alt_a, alt_b;
      ones  = '1;
      alt_a = {(spk_pkg::WORD_W/2){2'b10}};
      alt_b = {(spk_pkg::WORD_W/2){2'b01}};
      send_request(make_req(spk_pkg::MODE_ENCRYPT, '0, '0, '0, '0, '0, '0));
      send_request(make_req(spk_pkg::MODE_DECRYPT, '0, '0, '0, '0, '0, '0));
      send_request(make_req(spk_pkg::MODE_ENCRYPT, ones, ones, ones, ones, ones, ones));
      send_request(make_req(spk_pkg::MODE_DECRYPT, ones, ones, ones, ones, ones, ones));
      // Standard Speck48/96 vector: key 1a1918 121110 0a0908 020100,
      // plaintext 6d2073 696874; then decrypt its ciphertext 735e10 b6445d.
      send_request(make_req(spk_pkg::MODE_ENCRYPT, 24'h1a1918, 24'h121110, 24'h0a0908,
                            24'h020100, 24'h6d2073, 24'h696874));
      send_request(make_req(spk_pkg::MODE_DECRYPT, 24'h1a1918, 24'h121110, 24'h0a0908,
                            24'h020100, 24'h735e10, 24'hb6445d));
      send_request(make_req(spk_pkg::MODE_ENCRYPT, ones, ones, ones, ones, '0, '0));
      send_request(make_req(spk_pkg::MODE_DECRYPT, '0, '0, '0, '0, ones, ones));
      send_request(make_req(spk_pkg::MODE_ENCRYPT, alt_a, alt_b, alt_a, alt_b,
                            alt_a, alt_b));
      send_request(make_req(spk_pkg::MODE_DECRYPT, alt_b, alt_a, alt_b, alt_a,
                            alt_b, alt_a));
      // One key word at its maximum, the rest clear.
      send_request(make_req(spk_pkg::MODE_ENCRYPT, ones, '0, '0, '0, '0, '0));
      send_request(make_req(spk_pkg::MODE_ENCRYPT, '0, ones, '0, '0, '0, '0));
      send_request(make_req(spk_pkg::MODE_ENCRYPT, '0, '0, ones, '0, '0, '0));
      send_request(make_req(spk_pkg::MODE_ENCRYPT, '0, '0, '0, ones, '0, '0));
      // Single bits at the word edges, some mixed with all-ones words.
      send_request(make_req(spk_pkg::MODE_ENCRYPT, '0, '0, '0, 24'h800000,
                            24'h000001, '0));
      send_request(make_req(spk_pkg::MODE_DECRYPT, 24'h000001, '0, 24'h800000, '0, '0,
                            24'h800000));
      send_request(make_req(spk_pkg::MODE_ENCRYPT, '0, 24'h800000, '0, 24'h000001,
                            24'h800000, 24'h000001));
      send_request(make_req(spk_pkg::MODE_DECRYPT, ones, '0, ones, '0, 24'h000001, ones));
   endtask

   // -------------------------------------------------------------------------
   // Stimulus: reset, directed part, random bursts, drain and verdict
   // -------------------------------------------------------------------------
   initial begin
      int   sent;
      int   burst;
      int   gap;
      logic drained_mid;
      sent        = 0;
      drained_mid = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      hold_until_drained();

      while (sent < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            // About one pick in four is an encrypt/decrypt round trip.
            if ($urandom_range(0, 3) == 0) begin
               send_round_trip(random_req(spk_pkg::MODE_ENCRYPT));
               sent += 2;
            end else begin
               send_request(random_req(logic'($urandom_range(0, 1))));
               sent++;
            end
         end
         if (!drained_mid && sent >= RANDOM_REQUESTS / 2) begin
            // Let the whole pipeline empty once mid-run.
            drained_mid = 1'b1;
            hold_until_drained();
         end else begin
            // Back-to-back bursts are common; otherwise drop start for a random idle gap.
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/spk_pkg.sv
design/spk_key_stage.sv
design/spk_round_stage.sv
design/speck48_96_block_cipher_core.sv
verif/speck48_96_block_cipher_core_tb.sv
